@@ src/pis_pkg.sv @@
// ============================================================================
// pis_pkg: shared types and constants of the 2D projectile intercept solver
// Request and result words, status codes and the divider quotient width.
// ============================================================================
`timescale 1ns / 1ps

package pis_pkg;

    // request word, Q16.16 raw fixed point
    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_vx;
        logic signed [31:0] target_vy;
        logic signed [31:0] launch_x;
        logic signed [31:0] launch_y;
        logic        [30:0] projectile_speed;
    } in_word_t;

    // result word
    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] flight_time;
        logic signed [31:0] launch_vx;
        logic signed [31:0] launch_vy;
        logic signed [31:0] intercept_x;
        logic signed [31:0] intercept_y;
    } out_word_t;

    localparam logic [1:0] ST_NO_SOLUTION = 2'd0;
    localparam logic [1:0] ST_SOLVED      = 2'd1;
    localparam logic [1:0] ST_DEGENERATE  = 2'd2;

    // quotient magnitude bits kept by the dividers; anything larger saturates
    localparam int QUO_W = 35;

endpackage

@@ src/pis_div.sv @@
// ============================================================================
// pis_div: pipelined signed divider, round to nearest, ties away from zero
// One quotient bit per stage; flags quotients of 2^QUO_W and above.
// ============================================================================
`timescale 1ns / 1ps

module pis_div import pis_pkg::*; #(
    parameter int NUM_W = 100,
    parameter int DEN_W = 67
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic        [QUO_W-1:0] quo,
    output logic                    neg,
    output logic                    ovf
);

    localparam int RW = NUM_W + 2;
    localparam int TW = RW + QUO_W;

    logic [NUM_W-1:0] an;
    logic [DEN_W-1:0] ad;
    logic [DEN_W:0]   dd_c;
    logic [TW-1:0]    nr_c;
    logic             ovf_c;

    logic [TW-1:0]    rem_reg [0:QUO_W-1];
    logic [DEN_W:0]   dd_reg  [0:QUO_W-1];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];

    // rounded quotient is floor((2|n| + |d|) / (2|d|))
    always_comb begin
        an    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ad    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        dd_c  = {ad, 1'b0};
        nr_c  = (TW'(an) << 1) + TW'(ad);
        ovf_c = nr_c >= (TW'(dd_c) << QUO_W);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= nr_c;
            dd_reg[0]  <= dd_c;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            ovf_reg[0] <= ovf_c;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - k;
        logic [TW-1:0] trial;
        logic          ge;

        assign trial = TW'(dd_reg[k-1]) << B;
        assign ge    = rem_reg[k-1] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]   <= ge ? (q_reg[k-1] | (QUO_W'(1) << B)) : q_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QUO_W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                    dd_reg[k]  <= dd_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[QUO_W];
    assign neg = neg_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

@@ src/projectile_intercept_solver_2d.sv @@
// ============================================================================
// projectile_intercept_solver_2d: constant speed lead-targeting solver in 2D
// Pipeline from accepted request word to result word: 6 setup
// stages, 64 square-root stages, 3 root/product stages, 36 divider stages
// and the output register. Throughput one word per cycle; a stall at the
// output freezes the whole pipe. Synchronous active-low reset clears valids.
// ============================================================================
`timescale 1ns / 1ps

module projectile_intercept_solver_2d import pis_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int SQ_N     = 64;              // one root bit per stage
    localparam int D_W      = 67;              // D and A as signed divisors
    localparam int VEL_W    = 100;             // DX*D and TVX*A numerators
    localparam int FT_W     = 67 + FRAC_BITS;  // A << FRAC_BITS numerator
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int SUM_W    = QUO_W + 2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // context carried down the pipe alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tvx;
        logic signed [31:0] tvy;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [65:0] a;      // DX^2 + DY^2
        logic signed [65:0] p;      // DX*TVX + DY*TVY
        logic               degen;  // zero x or y offset
        logic               nosol;  // negative discriminant
        logic               dzero;  // infinite flight time
    } ctx_t;

    // global stall: everything moves when the output register can move
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // stage 1: offsets
    // ------------------------------------------------------------------
    logic              v1_reg;
    ctx_t              c1_reg, c1_next;
    logic [30:0]       s1_reg;

    always_comb begin
        c1_next       = '0;
        c1_next.tx    = s_data.target_x;
        c1_next.ty    = s_data.target_y;
        c1_next.tvx   = s_data.target_vx;
        c1_next.tvy   = s_data.target_vy;
        c1_next.dx    = {s_data.target_x[31], s_data.target_x}
                      - {s_data.launch_x[31], s_data.launch_x};
        c1_next.dy    = {s_data.target_y[31], s_data.target_y}
                      - {s_data.launch_y[31], s_data.launch_y};
        c1_next.degen = (c1_next.dx == '0) || (c1_next.dy == '0);
    end

    // ------------------------------------------------------------------
    // stage 2: first-order products, each about 33 x 33
    // ------------------------------------------------------------------
    logic              v2_reg;
    ctx_t              c2_reg;
    logic signed [65:0] pxx_reg, pyy_reg;
    logic signed [64:0] pxv_reg, pyv_reg, pkx_reg, pky_reg;
    logic        [61:0] ss2_reg;

    // ------------------------------------------------------------------
    // stage 3: A, P and cross term K
    // ------------------------------------------------------------------
    logic              v3_reg;
    ctx_t              c3_reg, c3_next;
    logic signed [65:0] k3_reg;
    logic        [61:0] ss3_reg;

    always_comb begin
        c3_next   = c2_reg;
        c3_next.a = 66'($unsigned(pxx_reg)) + 66'($unsigned(pyy_reg));
        c3_next.p = 66'(pxv_reg) + 66'(pyv_reg);
    end

    // ------------------------------------------------------------------
    // stage 4: partial products of A*S^2 and K^2 (32/34-bit halves)
    // ------------------------------------------------------------------
    logic              v4_reg;
    ctx_t              c4_reg;
    logic [65:0]       ka_c;
    logic [63:0]       m0_reg, m3_reg, k0_reg;
    logic [61:0]       m1_reg;
    logic [65:0]       m2_reg, k1_reg;
    logic [67:0]       k2_reg;

    assign ka_c = k3_reg[65] ? 66'($unsigned(-k3_reg)) : 66'($unsigned(k3_reg));

    // ------------------------------------------------------------------
    // stage 5: sum partial products
    // ------------------------------------------------------------------
    logic              v5_reg;
    ctx_t              c5_reg;
    logic [127:0]      as5_reg;
    logic [131:0]      kk5_reg;

    // ------------------------------------------------------------------
    // stage 6: discriminant Q = A*S^2 - K^2
    // ------------------------------------------------------------------
    logic              v6_reg;
    ctx_t              c6_reg, c6_next;
    logic [127:0]      rem6_reg;
    logic [132:0]      q_c;

    always_comb begin
        q_c           = 133'(as5_reg) - 133'(kk5_reg);
        c6_next       = c5_reg;
        c6_next.nosol = q_c[132];
    end

    // ------------------------------------------------------------------
    // square root: restoring, one result bit per stage, MSB first.
    // rem holds Q - root^2; a bit is kept when rem >= 2*root*2^b + 4^b.
    // ------------------------------------------------------------------
    logic         vsq_reg     [0:SQ_N-1];
    ctx_t         csq_reg     [0:SQ_N-1];
    logic [63:0]  root_sq_reg [0:SQ_N-1];
    logic [127:0] rem_sq_reg  [0:SQ_N-2];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam int B = SQ_N - 1 - k;
        logic [127:0] rem_prev;
        logic [63:0]  root_prev;
        ctx_t         c_prev;
        logic         v_prev;
        logic [129:0] trial;
        logic         ge;

        if (k == 0) begin : g_first
            assign rem_prev  = rem6_reg;
            assign root_prev = '0;
            assign c_prev    = c6_reg;
            assign v_prev    = v6_reg;
        end else begin : g_next
            assign rem_prev  = rem_sq_reg[k-1];
            assign root_prev = root_sq_reg[k-1];
            assign c_prev    = csq_reg[k-1];
            assign v_prev    = vsq_reg[k-1];
        end

        assign trial = (130'(root_prev) << (B + 1)) | (130'(1) << (2 * B));
        assign ge    = {2'b00, rem_prev} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vsq_reg[k] <= 1'b0;
            end else if (en) begin
                vsq_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_sq_reg[k] <= ge ? (root_prev | (64'(1) << B)) : root_prev;
                csq_reg[k]     <= c_prev;
            end
        end

        if (k < SQ_N - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_sq_reg[k] <= ge ? 128'({2'b00, rem_prev} - trial) : rem_prev;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // root select: R' takes the sign of DX; plus root unless D <= 0
    // ------------------------------------------------------------------
    logic               vd_reg;
    ctx_t               cd_reg, cd_next;
    logic signed [66:0] dval_reg;
    logic signed [66:0] rp_c, p67_c, d1_c, d2_c, d_c;
    logic [63:0]        r_c;

    always_comb begin
        r_c     = root_sq_reg[SQ_N-1];
        cd_next = csq_reg[SQ_N-1];
        rp_c    = cd_next.dx[32] ? -$signed({3'b000, r_c}) : $signed({3'b000, r_c});
        p67_c   = 67'(cd_next.p);
        d1_c    = rp_c - p67_c;
        d2_c    = -rp_c - p67_c;
        d_c     = (!d1_c[66] && (d1_c != '0)) ? d1_c : d2_c;
        cd_next.dzero = (d_c == '0);
    end

    // ------------------------------------------------------------------
    // numerator partial products: D and A split at bit 32
    // ------------------------------------------------------------------
    logic               vm1_reg;
    ctx_t               cm1_reg;
    logic signed [66:0] dm1_reg;
    logic signed [65:0] lx0_reg, ly0_reg;
    logic signed [67:0] lx1_reg, ly1_reg;
    logic signed [64:0] ix0_reg, iy0_reg;
    logic signed [66:0] ix1_reg, iy1_reg;

    logic               vm2_reg;
    ctx_t               cm2_reg;
    logic signed [66:0] dm2_reg, adiv_reg;
    logic signed [VEL_W-1:0] nlx_reg, nly_reg, nix_reg, niy_reg;
    logic signed [FT_W-1:0]  nft_reg;

    // ------------------------------------------------------------------
    // stage payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg  <= c1_next;
            s1_reg  <= s_data.projectile_speed;

            c2_reg  <= c1_reg;
            pxx_reg <= $signed(c1_reg.dx) * $signed(c1_reg.dx);
            pyy_reg <= $signed(c1_reg.dy) * $signed(c1_reg.dy);
            pxv_reg <= $signed(c1_reg.dx) * $signed(c1_reg.tvx);
            pyv_reg <= $signed(c1_reg.dy) * $signed(c1_reg.tvy);
            pkx_reg <= $signed(c1_reg.tvx) * $signed(c1_reg.dy);
            pky_reg <= $signed(c1_reg.tvy) * $signed(c1_reg.dx);
            ss2_reg <= s1_reg * s1_reg;

            c3_reg  <= c3_next;
            k3_reg  <= 66'(pkx_reg) - 66'(pky_reg);
            ss3_reg <= ss2_reg;

            c4_reg  <= c3_reg;
            m0_reg  <= c3_reg.a[31:0]  * ss3_reg[31:0];
            m1_reg  <= c3_reg.a[31:0]  * ss3_reg[61:32];
            m2_reg  <= c3_reg.a[65:32] * ss3_reg[31:0];
            m3_reg  <= c3_reg.a[65:32] * ss3_reg[61:32];
            k0_reg  <= ka_c[31:0]  * ka_c[31:0];
            k1_reg  <= ka_c[31:0]  * ka_c[65:32];
            k2_reg  <= ka_c[65:32] * ka_c[65:32];

            c5_reg  <= c4_reg;
            as5_reg <= 128'(m0_reg) + (128'(m1_reg) << 32) + (128'(m2_reg) << 32)
                     + (128'(m3_reg) << 64);
            kk5_reg <= 132'(k0_reg) + (132'(k1_reg) << 33) + (132'(k2_reg) << 64);

            c6_reg   <= c6_next;
            rem6_reg <= q_c[132] ? '0 : q_c[127:0];

            cd_reg   <= cd_next;
            dval_reg <= d_c;

            cm1_reg <= cd_reg;
            dm1_reg <= dval_reg;
            lx0_reg <= $signed(cd_reg.dx) * $signed({1'b0, dval_reg[31:0]});
            lx1_reg <= $signed(cd_reg.dx) * $signed(dval_reg[66:32]);
            ly0_reg <= $signed(cd_reg.dy) * $signed({1'b0, dval_reg[31:0]});
            ly1_reg <= $signed(cd_reg.dy) * $signed(dval_reg[66:32]);
            ix0_reg <= $signed(cd_reg.tvx) * $signed({1'b0, cd_reg.a[31:0]});
            ix1_reg <= $signed(cd_reg.tvx) * $signed({1'b0, cd_reg.a[65:32]});
            iy0_reg <= $signed(cd_reg.tvy) * $signed({1'b0, cd_reg.a[31:0]});
            iy1_reg <= $signed(cd_reg.tvy) * $signed({1'b0, cd_reg.a[65:32]});

            cm2_reg  <= cm1_reg;
            dm2_reg  <= dm1_reg;
            adiv_reg <= $signed({1'b0, cm1_reg.a});
            nlx_reg  <= VEL_W'(lx0_reg) + (VEL_W'(lx1_reg) <<< 32);
            nly_reg  <= VEL_W'(ly0_reg) + (VEL_W'(ly1_reg) <<< 32);
            nix_reg  <= VEL_W'(ix0_reg) + (VEL_W'(ix1_reg) <<< 32);
            niy_reg  <= VEL_W'(iy0_reg) + (VEL_W'(iy1_reg) <<< 32);
            nft_reg  <= FT_W'($signed({1'b0, cm1_reg.a})) <<< FRAC_BITS;
        end
    end

    // ------------------------------------------------------------------
    // dividers: flight time and intercepts over D, velocities over A
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] q_ft, q_lx, q_ly, q_ix, q_iy;
    logic             n_ft, n_lx, n_ly, n_ix, n_iy;
    logic             o_ft, o_lx, o_ly, o_ix, o_iy;

    pis_div #(.NUM_W(FT_W), .DEN_W(D_W)) u_div_ft (
        .aclk(aclk), .en(en), .num(nft_reg), .den(dm2_reg),
        .quo(q_ft), .neg(n_ft), .ovf(o_ft)
    );

    pis_div #(.NUM_W(VEL_W), .DEN_W(D_W)) u_div_lx (
        .aclk(aclk), .en(en), .num(nlx_reg), .den(adiv_reg),
        .quo(q_lx), .neg(n_lx), .ovf(o_lx)
    );

    pis_div #(.NUM_W(VEL_W), .DEN_W(D_W)) u_div_ly (
        .aclk(aclk), .en(en), .num(nly_reg), .den(adiv_reg),
        .quo(q_ly), .neg(n_ly), .ovf(o_ly)
    );

    pis_div #(.NUM_W(VEL_W), .DEN_W(D_W)) u_div_ix (
        .aclk(aclk), .en(en), .num(nix_reg), .den(dm2_reg),
        .quo(q_ix), .neg(n_ix), .ovf(o_ix)
    );

    pis_div #(.NUM_W(VEL_W), .DEN_W(D_W)) u_div_iy (
        .aclk(aclk), .en(en), .num(niy_reg), .den(dm2_reg),
        .quo(q_iy), .neg(n_iy), .ovf(o_iy)
    );

    // context rides alongside the dividers
    logic vdv_reg [0:DIV_LAT-1];
    ctx_t cdv_reg [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            cdv_reg[0] <= cm2_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                cdv_reg[i] <= cdv_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // valid chain
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            vd_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                vdv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            vd_reg  <= vsq_reg[SQ_N-1];
            vm1_reg <= vd_reg;
            vm2_reg <= vm1_reg;
            vdv_reg[0] <= vm2_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                vdv_reg[i] <= vdv_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // result assembly: signed quotient plus base, saturated to 32 bits
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] sat_add(
        input logic [QUO_W-1:0] q,
        input logic             qneg,
        input logic             qovf,
        input logic signed [31:0] base
    );
        logic signed [SUM_W-1:0] sq;
        logic signed [SUM_W-1:0] sum;
        logic                    fits;
        sq   = qneg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum  = sq + SUM_W'(base);
        fits = (sum[SUM_W-1:31] == '0) || (sum[SUM_W-1:31] == '1);
        if (qovf) begin
            sat_add = qneg ? SAT_MIN : SAT_MAX;
        end else if (!fits) begin
            sat_add = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            sat_add = sum[31:0];
        end
    endfunction

    out_word_t out_reg, out_next;
    ctx_t      cf;

    always_comb begin
        cf       = cdv_reg[DIV_LAT-1];
        out_next = '0;
        if (cf.degen) begin
            out_next.status = ST_DEGENERATE;
        end else if (cf.nosol) begin
            out_next.status = ST_NO_SOLUTION;
        end else if (cf.dzero) begin
            // target never reached: time pinned high, intercept runs off
            out_next.status      = ST_SOLVED;
            out_next.flight_time = SAT_MAX;
            out_next.launch_vx   = cf.tvx;
            out_next.launch_vy   = cf.tvy;
            out_next.intercept_x = (cf.tvx == '0) ? cf.tx : (cf.tvx[31] ? SAT_MIN : SAT_MAX);
            out_next.intercept_y = (cf.tvy == '0) ? cf.ty : (cf.tvy[31] ? SAT_MIN : SAT_MAX);
        end else begin
            out_next.status      = ST_SOLVED;
            out_next.flight_time = sat_add(q_ft, n_ft, o_ft, '0);
            out_next.launch_vx   = sat_add(q_lx, n_lx, o_lx, cf.tvx);
            out_next.launch_vy   = sat_add(q_ly, n_ly, o_ly, cf.tvy);
            out_next.intercept_x = sat_add(q_ix, n_ix, o_ix, cf.tx);
            out_next.intercept_y = sat_add(q_iy, n_iy, o_iy, cf.ty);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vdv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ dv/tb.sv @@
// ============================================================================
// tb: self-checking bench for projectile_intercept_solver_2d
// Drives a table of directed request words, then constrained-random and raw
// random words, through bursty valid/ready traffic. Results are checked field
// by field against the row's result or an exact wide-integer model held here.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import pis_pkg::*;

    localparam int  FRAC      = 16;
    localparam int  N_RANDOM  = 930;
    localparam int  LATENCY   = 110;
    localparam int  STALL_LEN = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    // wide enough that no intermediate of the solver wraps
    typedef logic signed [255:0] wide_t;

    typedef struct {
        in_word_t  req;
        bit        typed;   // expected result written in the row
        out_word_t res;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    out_word_t pending_q[$];
    int        n_errors = 0;
    int        n_sent;
    longint    n_cycles = 0;
    bit        in_reset;

    projectile_intercept_solver_2d #(.FRAC_BITS(FRAC)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Solver model
    // ------------------------------------------------------------------

    // quotient to nearest, ties away from zero
    function automatic wide_t div_nearest(wide_t n, wide_t d);
        bit    flip;
        wide_t an;
        wide_t ad;
        wide_t q;
        flip = (n < 0) != (d < 0);
        an   = (n < 0) ? -n : n;
        ad   = (d < 0) ? -d : d;
        q    = (2 * an + ad) / (2 * ad);
        return flip ? -q : q;
    endfunction

    function automatic logic [31:0] clamp32(wide_t a);
        if (a > wide_t'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (a < -(wide_t'(1) <<< 31))    return 32'h8000_0000;
        return a[31:0];
    endfunction

    // floor square root, kept to 64 bits
    function automatic wide_t root64(wide_t q);
        logic [63:0] r;
        logic [63:0] c;
        wide_t       wc;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            wc = '0;
            wc[63:0] = c;
            if (wc * wc <= q) r = c;
        end
        wc = '0;
        wc[63:0] = r;
        return wc;
    endfunction

    function automatic out_word_t solve_intercept(in_word_t w);
        out_word_t o;
        wide_t tx, ty, tvx, tvy, spd, dx, dy;
        wide_t a, p, k, q, r, d;
        tx  = wide_t'(w.target_x);
        ty  = wide_t'(w.target_y);
        tvx = wide_t'(w.target_vx);
        tvy = wide_t'(w.target_vy);
        spd = '0;
        spd[30:0] = w.projectile_speed;
        dx  = tx - wide_t'(w.launch_x);
        dy  = ty - wide_t'(w.launch_y);
        o   = '0;
        if (dx == 0 || dy == 0) begin
            o.status = ST_DEGENERATE;
            return o;
        end
        a = dx * dx + dy * dy;
        p = dx * tvx + dy * tvy;
        k = tvx * dy - tvy * dx;
        q = a * spd * spd - k * k;
        if (q < 0) begin
            o.status = ST_NO_SOLUTION;
            return o;
        end
        r = root64(q);
        if (dx < 0) r = -r;
        // plus root unless it gives a non-positive time
        d = r - p;
        if (d <= 0) d = -r - p;
        o.status = ST_SOLVED;
        if (d == 0) begin
            o.flight_time = 32'h7FFF_FFFF;
            o.launch_vx   = w.target_vx;
            o.launch_vy   = w.target_vy;
            o.intercept_x = (tvx == 0) ? w.target_x :
                            (tvx > 0 ? 32'h7FFF_FFFF : 32'h8000_0000);
            o.intercept_y = (tvy == 0) ? w.target_y :
                            (tvy > 0 ? 32'h7FFF_FFFF : 32'h8000_0000);
            return o;
        end
        o.flight_time = clamp32(div_nearest(a <<< FRAC, d));
        o.launch_vx   = clamp32(tvx + div_nearest(dx * d, a));
        o.launch_vy   = clamp32(tvy + div_nearest(dy * d, a));
        o.intercept_x = clamp32(tx + div_nearest(tvx * a, d));
        o.intercept_y = clamp32(ty + div_nearest(tvy * a, d));
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, n_cycles);
        n_errors++;
    endtask

    // cycle limit and result checking share the clock edge
    always @(posedge aclk) begin
        out_word_t want;
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (!in_reset && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected word", 32'(m_data.status), '0);
            end else begin
                want = pending_q.pop_front();
                if (m_data.status != want.status)
                    report("status", 32'(m_data.status), 32'(want.status));
                if (m_data.flight_time != want.flight_time)
                    report("flight_time", m_data.flight_time, want.flight_time);
                if (m_data.launch_vx != want.launch_vx)
                    report("launch_vx", m_data.launch_vx, want.launch_vx);
                if (m_data.launch_vy != want.launch_vy)
                    report("launch_vy", m_data.launch_vy, want.launch_vy);
                if (m_data.intercept_x != want.intercept_x)
                    report("intercept_x", m_data.intercept_x, want.intercept_x);
                if (m_data.intercept_y != want.intercept_y)
                    report("intercept_y", m_data.intercept_y, want.intercept_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern, plus one long hold-off so the pipe
    // backs up all the way to s_ready.
    // ------------------------------------------------------------------
    initial begin
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (in_reset) @(posedge aclk);
        forever begin
            if (!held && n_sent >= 200) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
            end else if (n_cycles % 96 < 24) begin
                m_ready <= 1'b1;              // stretch with no stalls
                @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) < 65);
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    int burst_left;

    // hold the word until accepted, then record what should come back
    task automatic send_word(in_word_t w, bit typed, out_word_t res);
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(typed ? res : solve_intercept(w));
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(20);
            if ($urandom_range(3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    function automatic in_word_t make_req(int tx, int ty, int vx, int vy,
                                          int lx, int ly, int unsigned spd);
        in_word_t w;
        w.target_x  = tx;
        w.target_y  = ty;
        w.target_vx = vx;
        w.target_vy = vy;
        w.launch_x  = lx;
        w.launch_y  = ly;
        w.projectile_speed = spd[30:0];
        return w;
    endfunction

    function automatic out_word_t make_res(logic [1:0] st, int ft, int vx, int vy,
                                           int ix, int iy);
        out_word_t o;
        o.status      = st;
        o.flight_time = ft;
        o.launch_vx   = vx;
        o.launch_vy   = vy;
        o.intercept_x = ix;
        o.intercept_y = iy;
        return o;
    endfunction

    // well-formed request: moderate geometry, fast projectile
    function automatic in_word_t sane_req();
        in_word_t w;
        w.target_x  = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        w.target_y  = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        w.target_vx = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        w.target_vy = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        w.launch_x  = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        w.launch_y  = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        w.projectile_speed = 31'($urandom_range(32'h0040_0000, 32'h0008_0000));
        return w;
    endfunction

    localparam int ONE  = 32'sh0001_0000;
    localparam int MAXI = 32'sh7FFF_FFFF;
    localparam int MINI = 32'sh8000_0000;

    dir_row_t dir_rows[$];

    initial begin
        in_word_t  w;
        out_word_t none;
        int        pick;

        none       = '0;
        n_sent     = 0;
        burst_left = 0;
        in_reset   = 1'b1;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;

        // zero offsets give degenerate status, everything else zero
        dir_rows.push_back('{make_req(5*ONE, 7*ONE, ONE, ONE, 5*ONE, 0, ONE), 1,
                             make_res(ST_DEGENERATE, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{make_req(3*ONE, -ONE, ONE, -ONE, 0, -ONE, ONE), 1,
                             make_res(ST_DEGENERATE, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{make_req(MAXI, MINI, MAXI, MINI, MAXI, MINI, 31'h7FFF_FFFF),
                             1, make_res(ST_DEGENERATE, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{make_req(0, 0, 0, 0, 0, 0, 0), 1,
                             make_res(ST_DEGENERATE, 0, 0, 0, 0, 0)});
        // target moving sideways, projectile at rest: no solution
        dir_rows.push_back('{make_req(ONE, ONE, ONE, 0, 0, 0, 0), 1,
                             make_res(ST_NO_SOLUTION, 0, 0, 0, 0, 0)});
        // still target, still projectile: infinite time, intercept at target
        dir_rows.push_back('{make_req(ONE, 2*ONE, 0, 0, 0, 0, 0), 1,
                             make_res(ST_SOLVED, MAXI, 0, 0, ONE, 2*ONE)});
        dir_rows.push_back('{make_req(-3, 9, 0, 0, 4, -4, 0), 1,
                             make_res(ST_SOLVED, MAXI, 0, 0, -3, 9)});
        // plain cases, predictor checked
        dir_rows.push_back('{make_req(10*ONE, 10*ONE, 0, 0, 0, 0, ONE), 0, none});
        dir_rows.push_back('{make_req(-10*ONE, 4*ONE, ONE, 0, 0, 0, 4*ONE), 0, none});
        dir_rows.push_back('{make_req(10*ONE, -3*ONE, -2*ONE, ONE, ONE, ONE, 3*ONE),
                             0, none});
        // target receding faster than projectile: minus root, negative time
        dir_rows.push_back('{make_req(10*ONE, 10*ONE, 5*ONE, 5*ONE, 0, 0, ONE), 0, none});
        dir_rows.push_back('{make_req(-10*ONE, -10*ONE, -5*ONE, -4*ONE, 0, 0, 2*ONE),
                             0, none});
        // extremes of every field
        dir_rows.push_back('{make_req(MAXI, MAXI, MAXI, MAXI, MINI, MINI, 31'h7FFF_FFFF),
                             0, none});
        dir_rows.push_back('{make_req(MINI, MINI, MINI, MINI, MAXI, MAXI, 31'h7FFF_FFFF),
                             0, none});
        dir_rows.push_back('{make_req(MAXI, MINI, MINI, MAXI, MINI, MAXI, 1), 0, none});
        dir_rows.push_back('{make_req(1, -1, 1, -1, 0, 0, 1), 0, none});
        dir_rows.push_back('{make_req(MAXI, 1, 0, 0, MINI, 0, 31'h7FFF_FFFF), 0, none});
        dir_rows.push_back('{make_req(1, 1, MAXI, MINI, 0, 0, 31'h7FFF_FFFF), 0, none});

        repeat (10) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);
        in_reset = 1'b0;

        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                w = sane_req();
            end else if (pick < 93) begin
                w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     31'($urandom)};
            end else begin
                w = sane_req();
                if (pick < 96) w.launch_x = w.target_x;
                else           w.launch_y = w.target_y;
            end
            send_word(w, 1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 40) @(posedge aclk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ projectile_intercept_solver_2d.f @@
src/pis_pkg.sv
src/pis_div.sv
src/projectile_intercept_solver_2d.sv
dv/tb.sv
